// File: design/dzgc_pkg.sv
// ----------------------------------------------------------------------------
// dzgc_pkg
// Shared types and constants of the calibrated DAC driver: opcodes, register
// indexes, field widths, configuration and result bundles.
// ----------------------------------------------------------------------------
package dzgc_pkg;

	localparam int unsigned OP_W      = 4;
	localparam int unsigned VAL_W     = 16;
	localparam int unsigned SHIFT_W   = 5;
	localparam int unsigned TICKS_W   = 7;
	localparam int unsigned TIMER_W   = 8;
	localparam int unsigned REQ_W     = 2;
	localparam int unsigned PROD_W    = 2 * VAL_W;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned IN_W      = 24;
	localparam int unsigned OUT_W     = 40;

	localparam logic [VAL_W-1:0]   SAT_MAX   = 16'hFFFF;
	localparam logic [TIMER_W-1:0] GAIN_FLAG = 8'h80;

	// reset values
	localparam logic [SHIFT_W-1:0] RST_GAIN_SHIFT = 5'd12;
	localparam logic [TICKS_W-1:0] RST_LOCK_TICKS = 7'd120;
	localparam logic [VAL_W-1:0]   RST_ZERO_OUT   = 16'd13107;
	localparam logic [VAL_W-1:0]   RST_MAX_OUT    = 16'hFFFF;
	localparam logic [VAL_W-1:0]   RST_FULL_SCALE = 16'hFFFF;
	localparam logic [VAL_W-1:0]   RST_GAIN_WORD  = 16'd4096;

	typedef enum logic [OP_W-1:0] {
		OP_TICK       = 4'd0,
		OP_UPDATE     = 4'd1,
		OP_INV_UPDATE = 4'd2,
		OP_ZERO_OUT   = 4'd3,
		OP_MAX_OUT    = 4'd4,
		OP_ZERO_MODE  = 4'd5,
		OP_SET_ZERO   = 4'd6,
		OP_SAVE_ZERO  = 4'd7,
		OP_GAIN_MODE  = 4'd8,
		OP_SET_GAIN   = 4'd9,
		OP_SAVE_GAIN  = 4'd10
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_SHIFT = 3'd0,
		REG_LOCK_TICKS = 3'd1,
		REG_ZERO_OUT   = 3'd2,
		REG_MAX_OUT    = 3'd3,
		REG_FULL_SCALE = 3'd4
	} reg_idx_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_NONE = 2'd0,
		REQ_ZERO = 2'd1,
		REQ_GAIN = 2'd2
	} store_req_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] gain_shift;
		logic [TICKS_W-1:0] lock_ticks;
		logic [VAL_W-1:0]   zero_output_code;
		logic [VAL_W-1:0]   max_output_code;
		logic [VAL_W-1:0]   full_scale_value;
	} cfg_t;

	typedef struct packed {
		logic             dac_write;
		logic [VAL_W-1:0] dac_code;
		store_req_t       store_request;
		logic [VAL_W-1:0] stored_value;
		logic             locked;
	} result_t;

endpackage

// File: design/dzgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dzgc_cfg_regs
// Configuration register file; one indexed write per request, unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
module dzgc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [dzgc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [dzgc_pkg::VAL_W-1:0]      wr_data,
	output dzgc_pkg::cfg_t                  cfg
);
	import dzgc_pkg::*;

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_shift       <= RST_GAIN_SHIFT;
			cfg_q.lock_ticks       <= RST_LOCK_TICKS;
			cfg_q.zero_output_code <= RST_ZERO_OUT;
			cfg_q.max_output_code  <= RST_MAX_OUT;
			cfg_q.full_scale_value <= RST_FULL_SCALE;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_GAIN_SHIFT: cfg_q.gain_shift       <= wr_data[SHIFT_W-1:0];
				REG_LOCK_TICKS: cfg_q.lock_ticks       <= wr_data[TICKS_W-1:0];
				REG_ZERO_OUT:   cfg_q.zero_output_code <= wr_data;
				REG_MAX_OUT:    cfg_q.max_output_code  <= wr_data;
				REG_FULL_SCALE: cfg_q.full_scale_value <= wr_data;
				default:        ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/dzgc_core.sv
// ----------------------------------------------------------------------------
// dzgc_core
// Calibration state (zero code, gain word, lock timer) and the per-opcode
// datapath: scale, offset, saturate, lock handling and store requests.
// ----------------------------------------------------------------------------
module dzgc_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [dzgc_pkg::OP_W-1:0]   opcode,
	input  logic [dzgc_pkg::VAL_W-1:0]  operand_value,
	input  dzgc_pkg::cfg_t              cfg,
	output dzgc_pkg::result_t           result
);
	import dzgc_pkg::*;

	logic [VAL_W-1:0]   zero_code_q;
	logic [VAL_W-1:0]   gain_word_q;
	logic [TIMER_W-1:0] lock_timer_q;

	logic [VAL_W-1:0]   mul_a;
	logic [VAL_W-1:0]   mul_b;
	logic [PROD_W-1:0]  product;
	logic [PROD_W-1:0]  scaled;
	logic [PROD_W:0]    fwd_sum;
	logic [VAL_W-1:0]   fwd_code;
	logic [VAL_W-1:0]   inv_code;
	logic [TIMER_W-1:0] tick_dec;
	logic [TIMER_W-1:0] tick_next;
	logic [TIMER_W-1:0] timer_next;
	logic [VAL_W-1:0]   zero_next;
	logic [VAL_W-1:0]   gain_next;
	logic               unlocked;
	logic               gain_cal;

	// gain calibration scales full scale; set gain uses the new gain at once
	assign gain_cal = (opcode_t'(opcode) == OP_GAIN_MODE) || (opcode_t'(opcode) == OP_SET_GAIN);
	assign mul_a    = gain_cal ? cfg.full_scale_value : operand_value;
	assign mul_b    = (opcode_t'(opcode) == OP_SET_GAIN) ? operand_value : gain_word_q;
	assign product  = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign scaled   = product >> cfg.gain_shift;

	// forward path: offset and saturate
	assign fwd_sum  = {1'b0, scaled} + (PROD_W + 1)'(zero_code_q);
	assign fwd_code = (fwd_sum >= (PROD_W + 1)'(SAT_MAX)) ? SAT_MAX : fwd_sum[VAL_W-1:0];

	// inverted path: zero minus scaled value, floored at zero
	assign inv_code = (PROD_W'(zero_code_q) > scaled) ?
	                  (zero_code_q - scaled[VAL_W-1:0]) : '0;

	// tick: count down, a gain lock that reaches the flag alone ends
	assign tick_dec  = lock_timer_q - TIMER_W'(1);
	assign tick_next = (lock_timer_q == '0) ? '0 :
	                   ((tick_dec == GAIN_FLAG) ? '0 : tick_dec);

	assign unlocked = (lock_timer_q == '0);

	// per-opcode outcome
	always_comb begin
		timer_next           = lock_timer_q;
		zero_next            = zero_code_q;
		gain_next            = gain_word_q;
		result.dac_write     = 1'b0;
		result.dac_code      = '0;
		result.store_request = REQ_NONE;
		result.stored_value  = '0;
		unique case (opcode_t'(opcode))
			OP_TICK: begin
				timer_next = tick_next;
			end
			OP_UPDATE: begin
				result.dac_write = unlocked;
				result.dac_code  = unlocked ? fwd_code : '0;
			end
			OP_INV_UPDATE: begin
				result.dac_write = unlocked;
				result.dac_code  = unlocked ? inv_code : '0;
			end
			OP_ZERO_OUT: begin
				result.dac_write = unlocked;
				result.dac_code  = unlocked ? cfg.zero_output_code : '0;
			end
			OP_MAX_OUT: begin
				result.dac_write = 1'b1;
				result.dac_code  = cfg.max_output_code;
			end
			OP_ZERO_MODE: begin
				timer_next       = {1'b0, cfg.lock_ticks};
				result.dac_write = 1'b1;
				result.dac_code  = zero_code_q;
			end
			OP_SET_ZERO: begin
				timer_next       = {1'b0, cfg.lock_ticks};
				zero_next        = operand_value;
				result.dac_write = 1'b1;
				result.dac_code  = operand_value;
			end
			OP_SAVE_ZERO: begin
				timer_next           = '0;
				result.store_request = REQ_ZERO;
				result.stored_value  = zero_code_q;
			end
			OP_GAIN_MODE: begin
				timer_next       = GAIN_FLAG | {1'b0, cfg.lock_ticks};
				result.dac_write = 1'b1;
				result.dac_code  = fwd_code;
			end
			OP_SET_GAIN: begin
				timer_next       = GAIN_FLAG | {1'b0, cfg.lock_ticks};
				gain_next        = operand_value;
				result.dac_write = 1'b1;
				result.dac_code  = fwd_code;
			end
			OP_SAVE_GAIN: begin
				timer_next           = '0;
				result.store_request = REQ_GAIN;
				result.stored_value  = gain_word_q;
			end
			default: ;
		endcase
		result.locked = (timer_next != '0);
	end

	// calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_code_q  <= '0;
			gain_word_q  <= RST_GAIN_WORD;
			lock_timer_q <= '0;
		end else if (fire) begin
			zero_code_q  <= zero_next;
			gain_word_q  <= gain_next;
			lock_timer_q <= timer_next;
		end
	end

endmodule

// File: design/dac_zero_gain_calibrator_top.sv
// Path: a request accepted into the input register moves into the result
// register when that register is free (input register, then result register).
// Throughput: one request per cycle while m_axis_tready holds; the state update
// path runs through the 16x16 multiplier, shifter and offset adder.
// Reset: arst_n clears both valid flags, loads the configuration registers with
// their defaults and sets the calibration state (zero code 0, gain 4096, lock 0).
// ----------------------------------------------------------------------------
// dac_zero_gain_calibrator_top
// Calibrated DAC driver with two-point zero and gain calibration, stream in,
// stream out, and an indexed configuration write channel.
// ----------------------------------------------------------------------------
module dac_zero_gain_calibrator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// request stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [3:0] opcode, [19:4] operand_value, [23:20] zero
	input  logic [dzgc_pkg::IN_W-1:0]       s_axis_tdata,
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [0] dac_write, [16:1] dac_code, [18:17] store_request,
	// [34:19] stored_value, [35] locked, [39:36] zero
	output logic [dzgc_pkg::OUT_W-1:0]      m_axis_tdata,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dzgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dzgc_pkg::VAL_W-1:0]      cfg_data
);
	import dzgc_pkg::*;

	logic             valid_s1;
	logic [OP_W-1:0]  opcode_s1;
	logic [VAL_W-1:0] operand_s1;
	logic             out_valid_q;
	result_t          out_q;
	result_t          result;
	cfg_t             cfg;
	logic             advance;
	logic             fire;

	assign cfg_ready = 1'b1;

	dzgc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// handshake: the result register frees as the consumer takes it
	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1  <= s_axis_tdata[OP_W-1:0];
			operand_s1 <= s_axis_tdata[OP_W+VAL_W-1:OP_W];
		end
	end

	dzgc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.opcode        (opcode_s1),
		.operand_value (operand_s1),
		.cfg           (cfg),
		.result        (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_q.locked, out_q.stored_value,
	                        out_q.store_request, out_q.dac_code, out_q.dac_write};

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calibrated DAC driver. Requests are driven on
// the input stream with random gaps, results are taken with random stalls,
// and every result is compared with a shadow of the calibration state kept in
// the bench. A directed table covers extremes, every opcode, locked updates,
// lock run-out and unknown opcodes; random phases follow, each with its own
// register settings, with random requests and calibration sessions of random content.
// ----------------------------------------------------------------------------
module tb;
	import dzgc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_ITEMS = 1700;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned MAX_GAP      = 17;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned REPORT_MAX   = 10;

	localparam logic [OP_W-1:0]      OP_UNUSED_LO = 4'd11;
	localparam logic [OP_W-1:0]      OP_UNUSED_HI = 4'd15;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// [3:0] opcode, [19:4] operand_value, [23:20] zero
	logic [IN_W-1:0]      s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// [0] dac_write, [16:1] dac_code, [18:17] store_request,
	// [34:19] stored_value, [35] locked, [39:36] zero
	logic [OUT_W-1:0]     m_axis_tdata;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [VAL_W-1:0]     cfg_data      = '0;

	dac_zero_gain_calibrator_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// shadow of the registers and calibration state
	cfg_t               cfg_shadow;
	logic [VAL_W-1:0]   zero_shadow;
	logic [VAL_W-1:0]   gain_shadow;
	logic [TIMER_W-1:0] lock_shadow;

	result_t     pending_outputs[$];
	int unsigned failures    = 0;
	int unsigned cycle_count = 0;
	int unsigned items_sent  = 0;
	int unsigned sink_hold   = 0;
	bit          src_calm    = 1'b0;
	bit          sink_calm   = 1'b0;

	typedef struct {
		bit                   is_cfg;
		logic [OP_W-1:0]      op;
		logic [CFG_IDX_W-1:0] idx;
		logic [VAL_W-1:0]     val;
		bit                   typed;
		result_t              res;
	} stim_row_t;

	stim_row_t stim_table[$];

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// gap per request, with calm stretches that have no gaps at all
	function automatic int unsigned pick_gap(inout bit calm);
		if ($urandom_range(0, 31) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return SAT_MAX;
		default: return VAL_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// value times gain, shifted down by the fractional bits
	function automatic logic [PROD_W-1:0] scale_value(input logic [VAL_W-1:0] v);
		logic [PROD_W-1:0] prod;
		prod = {{VAL_W{1'b0}}, v} * {{VAL_W{1'b0}}, gain_shadow};
		return prod >> cfg_shadow.gain_shift;
	endfunction

	// scaled value plus zero code, saturated
	function automatic logic [VAL_W-1:0] forward_code(input logic [VAL_W-1:0] v);
		logic [PROD_W:0] sum;
		sum = {1'b0, scale_value(v)} + {{(PROD_W-VAL_W+1){1'b0}}, zero_shadow};
		return (sum >= SAT_MAX) ? SAT_MAX : sum[VAL_W-1:0];
	endfunction

	// expected result of one request; advances the shadow state
	function automatic result_t calibrate_step(input logic [OP_W-1:0] op,
			input logic [VAL_W-1:0] val);
		result_t           r;
		logic [PROD_W-1:0] s;
		r = '0;
		case (op)
		OP_TICK: begin
			if (lock_shadow != 0) begin
				lock_shadow = lock_shadow - 1'b1;
				// a gain lock ends when only its flag is left
				if (lock_shadow == GAIN_FLAG)
					lock_shadow = '0;
			end
		end
		OP_UPDATE: begin
			if (lock_shadow == 0) begin
				r.dac_write = 1'b1;
				r.dac_code  = forward_code(val);
			end
		end
		OP_INV_UPDATE: begin
			if (lock_shadow == 0) begin
				s = scale_value(val);
				r.dac_write = 1'b1;
				r.dac_code  = ({{VAL_W{1'b0}}, zero_shadow} > s) ?
					zero_shadow - s[VAL_W-1:0] : '0;
			end
		end
		OP_ZERO_OUT: begin
			if (lock_shadow == 0) begin
				r.dac_write = 1'b1;
				r.dac_code  = cfg_shadow.zero_output_code;
			end
		end
		OP_MAX_OUT: begin
			r.dac_write = 1'b1;
			r.dac_code  = cfg_shadow.max_output_code;
		end
		OP_ZERO_MODE: begin
			lock_shadow = {1'b0, cfg_shadow.lock_ticks};
			r.dac_write = 1'b1;
			r.dac_code  = zero_shadow;
		end
		OP_SET_ZERO: begin
			lock_shadow = {1'b0, cfg_shadow.lock_ticks};
			zero_shadow = val;
			r.dac_write = 1'b1;
			r.dac_code  = val;
		end
		OP_SAVE_ZERO: begin
			r.store_request = REQ_ZERO;
			r.stored_value  = zero_shadow;
			lock_shadow     = '0;
		end
		OP_GAIN_MODE: begin
			lock_shadow = GAIN_FLAG | {1'b0, cfg_shadow.lock_ticks};
			r.dac_write = 1'b1;
			r.dac_code  = forward_code(cfg_shadow.full_scale_value);
		end
		OP_SET_GAIN: begin
			lock_shadow = GAIN_FLAG | {1'b0, cfg_shadow.lock_ticks};
			gain_shadow = val;
			r.dac_write = 1'b1;
			r.dac_code  = forward_code(cfg_shadow.full_scale_value);
		end
		OP_SAVE_GAIN: begin
			r.store_request = REQ_GAIN;
			r.stored_value  = gain_shadow;
			lock_shadow     = '0;
		end
		default: ;
		endcase
		r.locked = (lock_shadow != 0);
		return r;
	endfunction

	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [VAL_W-1:0] data);
		case (idx)
		REG_GAIN_SHIFT: cfg_shadow.gain_shift       = data[SHIFT_W-1:0];
		REG_LOCK_TICKS: cfg_shadow.lock_ticks       = data[TICKS_W-1:0];
		REG_ZERO_OUT:   cfg_shadow.zero_output_code = data;
		REG_MAX_OUT:    cfg_shadow.max_output_code  = data;
		REG_FULL_SCALE: cfg_shadow.full_scale_value = data;
		default: ;
		endcase
	endfunction

	// directed table entries
	function automatic void add_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
		stim_row_t row;
		row = '{1'b0, op, '0, val, 1'b0, '0};
		stim_table.push_back(row);
	endfunction

	function automatic void add_checked(input logic [OP_W-1:0] op,
			input logic [VAL_W-1:0] val, input logic w, input logic [VAL_W-1:0] code,
			input store_req_t req, input logic [VAL_W-1:0] stv, input logic lk);
		stim_row_t row;
		row = '{1'b0, op, '0, val, 1'b1, '0};
		row.res.dac_write     = w;
		row.res.dac_code      = code;
		row.res.store_request = req;
		row.res.stored_value  = stv;
		row.res.locked        = lk;
		stim_table.push_back(row);
	endfunction

	function automatic void add_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		stim_row_t row;
		row = '{1'b1, '0, idx, val, 1'b0, '0};
		stim_table.push_back(row);
	endfunction

	// one request: random gap, then hold until taken
	task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
			input bit typed, input result_t typed_res);
		int unsigned gap;
		result_t     predicted;
		gap = pick_gap(src_calm);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_W-OP_W-VAL_W){1'b0}}, val, op};
		predicted = calibrate_step(op, val);
		pending_outputs.push_back(typed ? typed_res : predicted);
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// register write; the caller lowers cfg_valid after its last write
	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [VAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(idx, data);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_outputs.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// result checking and receiver stalls
	always @(posedge clk) begin : result_sink
		result_t got;
		result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.dac_write     = m_axis_tdata[0];
			got.dac_code      = m_axis_tdata[16:1];
			got.store_request = store_req_t'(m_axis_tdata[18:17]);
			got.stored_value  = m_axis_tdata[34:19];
			got.locked        = m_axis_tdata[35];
			if (pending_outputs.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("unexpected result: w=%0d code=%0d req=%0d stv=%0d lock=%0d",
						got.dac_write, got.dac_code, got.store_request,
						got.stored_value, got.locked);
			end else begin
				want = pending_outputs.pop_front();
				if (got.dac_write !== want.dac_write || got.dac_code !== want.dac_code ||
						got.store_request !== want.store_request ||
						got.stored_value !== want.stored_value ||
						got.locked !== want.locked) begin
					failures++;
					if (failures <= REPORT_MAX) begin
						$display("mismatch: expected w=%0d code=%0d req=%0d stv=%0d lock=%0d",
							want.dac_write, want.dac_code, want.store_request,
							want.stored_value, want.locked);
						$display("          got      w=%0d code=%0d req=%0d stv=%0d lock=%0d",
							got.dac_write, got.dac_code, got.store_request,
							got.stored_value, got.locked);
					end
				end
			end
			sink_hold = pick_gap(sink_calm);
		end
		if (sink_hold != 0) begin
			m_axis_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin : stimulus
		int unsigned      phase_end;
		int unsigned      n;
		int unsigned      k;
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] data;

		cfg_shadow.gain_shift       = RST_GAIN_SHIFT;
		cfg_shadow.lock_ticks       = RST_LOCK_TICKS;
		cfg_shadow.zero_output_code = RST_ZERO_OUT;
		cfg_shadow.max_output_code  = RST_MAX_OUT;
		cfg_shadow.full_scale_value = RST_FULL_SCALE;
		zero_shadow = '0;
		gain_shadow = RST_GAIN_WORD;
		lock_shadow = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// extremes straight after reset
		add_checked(OP_UPDATE, 16'd0, 1'b1, 16'd0, REQ_NONE, 16'd0, 1'b0);
		add_checked(OP_UPDATE, 16'hFFFF, 1'b1, SAT_MAX, REQ_NONE, 16'd0, 1'b0);
		add_checked(OP_INV_UPDATE, 16'h1234, 1'b1, 16'd0, REQ_NONE, 16'd0, 1'b0);
		add_checked(OP_ZERO_OUT, 16'd0, 1'b1, RST_ZERO_OUT, REQ_NONE, 16'd0, 1'b0);
		add_checked(OP_MAX_OUT, 16'hFFFF, 1'b1, RST_MAX_OUT, REQ_NONE, 16'd0, 1'b0);
		add_checked(OP_TICK, 16'd0, 1'b0, 16'd0, REQ_NONE, 16'd0, 1'b0);
		// zero calibration holds off updates until saved
		add_checked(OP_SET_ZERO, 16'd1000, 1'b1, 16'd1000, REQ_NONE, 16'd0, 1'b1);
		add_checked(OP_UPDATE, 16'd5, 1'b0, 16'd0, REQ_NONE, 16'd0, 1'b1);
		add_checked(OP_ZERO_OUT, 16'd0, 1'b0, 16'd0, REQ_NONE, 16'd0, 1'b1);
		add_checked(OP_MAX_OUT, 16'd0, 1'b1, RST_MAX_OUT, REQ_NONE, 16'd0, 1'b1);
		add_checked(OP_SAVE_ZERO, 16'hFFFF, 1'b0, 16'd0, REQ_ZERO, 16'd1000, 1'b0);
		add_checked(OP_INV_UPDATE, 16'd500, 1'b1, 16'd500, REQ_NONE, 16'd0, 1'b0);
		add_item(OP_UPDATE, 16'd100);
		add_item(OP_ZERO_MODE, 16'd0);
		add_item(OP_TICK, 16'd0);
		// gain calibration at twice unity
		add_item(OP_SET_GAIN, 16'h2000);
		add_item(OP_GAIN_MODE, 16'hFFFF);
		add_checked(OP_SAVE_GAIN, 16'd0, 1'b0, 16'd0, REQ_GAIN, 16'h2000, 1'b0);
		// unknown opcodes change nothing
		add_checked(OP_UNUSED_HI, 16'hFFFF, 1'b0, 16'd0, REQ_NONE, 16'd0, 1'b0);
		add_checked(OP_UNUSED_LO, 16'd0, 1'b0, 16'd0, REQ_NONE, 16'd0, 1'b0);
		// gain lock running out through its flag
		add_setting(REG_LOCK_TICKS, 16'd2);
		add_item(OP_GAIN_MODE, 16'd0);
		add_item(OP_TICK, 16'd0);
		add_checked(OP_TICK, 16'd0, 1'b0, 16'd0, REQ_NONE, 16'd0, 1'b0);
		// zero lock length: zero mode stays unlocked, gain mode ticks through 0x7f
		add_setting(REG_LOCK_TICKS, 16'd0);
		add_checked(OP_ZERO_MODE, 16'd0, 1'b1, 16'd1000, REQ_NONE, 16'd0, 1'b0);
		add_item(OP_SET_GAIN, 16'hFFFF);
		add_item(OP_TICK, 16'd0);
		add_item(OP_SAVE_GAIN, 16'd0);
		// widest shift
		add_setting(REG_GAIN_SHIFT, 16'd31);
		add_item(OP_UPDATE, 16'hFFFF);

		foreach (stim_table[i]) begin
			if (stim_table[i].is_cfg) begin
				drain_results();
				write_setting(stim_table[i].idx, stim_table[i].val);
				cfg_valid <= 1'b0;
			end else begin
				send_request(stim_table[i].op, stim_table[i].val,
					stim_table[i].typed, stim_table[i].res);
			end
		end

		// random phases, each under its own settings
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			case (p)
			0: data = 16'd0;
			1: data = 16'd31;
			2: data = 16'd16;
			3: data = 16'd12;
			default: data = 16'($urandom_range(0, 31));
			endcase
			data[VAL_W-1:SHIFT_W] = (VAL_W-SHIFT_W)'($urandom_range(0, 2047));
			write_setting(REG_GAIN_SHIFT, data);
			case (p)
			0: data = 16'd127;
			1: data = 16'd0;
			2: data = 16'd1;
			default: data = 16'($urandom_range(0, 15));
			endcase
			data[VAL_W-1:TICKS_W] = (VAL_W-TICKS_W)'($urandom_range(0, 511));
			write_setting(REG_LOCK_TICKS, data);
			write_setting(REG_ZERO_OUT, (p == 0) ? 16'd0 : (p == 1) ? SAT_MAX : pick_value());
			write_setting(REG_MAX_OUT, (p == 0) ? 16'd0 : (p == 1) ? SAT_MAX : pick_value());
			write_setting(REG_FULL_SCALE, (p == 0) ? 16'd0 : (p == 1) ? SAT_MAX : pick_value());
			if (p == 3)
				write_setting(REG_UNUSED, pick_value());
			cfg_valid <= 1'b0;

			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 4) == 0) begin
					// calibration session: enter, tick a while, usually save
					case ($urandom_range(0, 3))
					0: op = OP_ZERO_MODE;
					1: op = OP_SET_ZERO;
					2: op = OP_GAIN_MODE;
					default: op = OP_SET_GAIN;
					endcase
					send_request(op, pick_value(), 1'b0, '0);
					n = $urandom_range(0, cfg_shadow.lock_ticks + 2);
					for (k = 0; k < n; k++)
						send_request(($urandom_range(0, 7) == 0) ? OP_UPDATE : OP_TICK,
							pick_value(), 1'b0, '0);
					if ($urandom_range(0, 3) != 0)
						send_request((op < OP_GAIN_MODE) ? OP_SAVE_ZERO : OP_SAVE_GAIN,
							pick_value(), 1'b0, '0);
				end else begin
					k = $urandom_range(0, 99);
					if (k < 30)      op = OP_TICK;
					else if (k < 50) op = OP_UPDATE;
					else if (k < 60) op = OP_INV_UPDATE;
					else if (k < 64) op = OP_ZERO_OUT;
					else if (k < 68) op = OP_MAX_OUT;
					else if (k < 73) op = OP_ZERO_MODE;
					else if (k < 78) op = OP_SET_ZERO;
					else if (k < 83) op = OP_SAVE_ZERO;
					else if (k < 87) op = OP_GAIN_MODE;
					else if (k < 92) op = OP_SET_GAIN;
					else if (k < 97) op = OP_SAVE_GAIN;
					else             op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
					send_request(op, pick_value(), 1'b0, '0);
				end
			end
		end

		drain_results();
		failures += pending_outputs.size();
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
design/dzgc_pkg.sv
design/dzgc_cfg_regs.sv
design/dzgc_core.sv
design/dac_zero_gain_calibrator_top.sv
test/tb.sv
